### design/voice_note_segmenter_core_defines.svh
// ---------------------------------------------------------------------------
// Voice note segmenter - assertion macros
// Shared property shorthands; clocked on clk, quiet while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef VOICE_NOTE_SEGMENTER_CORE_DEFINES_SVH
`define VOICE_NOTE_SEGMENTER_CORE_DEFINES_SVH

// condition holds in the same cycle
`define VNS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// condition holds in the next cycle
`define VNS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### design/vns_pkg.sv
// ---------------------------------------------------------------------------
// Voice note segmenter - package
// Word formats, register indexes and fixed constants.
// ---------------------------------------------------------------------------
package vns_pkg;

	localparam int FREQ_W      = 16;
	localparam int PITCH_W     = 15;
	localparam int CTRL_W      = 8;
	localparam int LEVEL_W     = 8;
	localparam int INST_W      = 4;
	localparam int NOTE_W      = 7;
	localparam int IO_TICK_W   = 20;
	localparam int ATTACK_W    = 3;
	localparam int VOICE_W     = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// log2 in Q16: 4 integer bits, 16 fraction bits
	localparam int LOG_FRAC_W  = 16;
	localparam int LOG_INT_W   = 4;
	localparam int LOG_W       = LOG_INT_W + LOG_FRAC_W;
	localparam int MANT_W      = 31;
	// one normalize stage plus one squaring stage per fraction bit
	localparam int LOG_LAT     = LOG_FRAC_W + 1;

	localparam logic [PITCH_W-1:0] PITCH_MAX = '1;
	localparam logic [NOTE_W-1:0]  NOTE_MAX  = '1;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL = '1;

	// item kinds
	localparam logic KIND_ATTACK = 1'b0;
	localparam logic KIND_VOICE  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLIDE_BAND   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VIBRATO_BAND = 3'd4;

	localparam logic [FREQ_W-1:0]  RST_MIN_FREQ     = 16'd279;
	localparam logic [FREQ_W-1:0]  RST_MAX_FREQ     = 16'd65535;
	localparam logic [PITCH_W-1:0] RST_JUMP_LIMIT   = 15'd179;
	localparam logic [PITCH_W-1:0] RST_SLIDE_BAND   = 15'd307;
	localparam logic [PITCH_W-1:0] RST_VIBRATO_BAND = 15'd640;

	typedef struct packed {
		logic                  kind;
		logic [VOICE_W-1:0]    voice;
		logic [ATTACK_W-1:0]   attack_bits;
		logic [IO_TICK_W-1:0]  tick;
		logic                  regs_valid;
		logic                  env_valid;
		logic [FREQ_W-1:0]     freq_word;
		logic [CTRL_W-1:0]     control;
		logic [LEVEL_W-1:0]    envelope;
	} in_item_t;

	typedef struct packed {
		logic [VOICE_W-1:0]    out_voice;
		logic [LEVEL_W-1:0]    volume;
		logic [INST_W-1:0]     instrument;
		logic [NOTE_W-1:0]     note_pitch;
		logic [IO_TICK_W-1:0]  note_start_tick;
		logic                  merge_back;
		logic [IO_TICK_W-1:0]  merge_first_tick;
		logic [IO_TICK_W-1:0]  merge_target_tick;
	} out_res_t;

endpackage

### design/vns_in_if.sv
// ---------------------------------------------------------------------------
// Voice note segmenter - input channel
// Valid/ready channel carrying attack polls and voice ticks.
// ---------------------------------------------------------------------------
interface vns_in_if import vns_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### design/vns_out_if.sv
// ---------------------------------------------------------------------------
// Voice note segmenter - result channel
// Valid/ready channel carrying one note word per in-range voice tick.
// ---------------------------------------------------------------------------
interface vns_out_if import vns_pkg::*; ();
	logic     valid;
	logic     ready;
	out_res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### design/vns_log2.sv
// ---------------------------------------------------------------------------
// Voice note segmenter - log2 pipeline
// Q16 log2 of a 16-bit word: leading-one stage, then one mantissa squaring
// per fraction bit. Advances while en is high.
// ---------------------------------------------------------------------------
module vns_log2 import vns_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [FREQ_W-1:0] x,
	output logic [LOG_W-1:0]  log_q16
);

	logic [LOG_INT_W-1:0]  lead;
	logic [MANT_W-1:0]     mant0;

	logic                  zero_s [0:LOG_FRAC_W];
	logic [LOG_INT_W-1:0]  exp_s  [0:LOG_FRAC_W];
	logic [LOG_FRAC_W-1:0] frac_s [0:LOG_FRAC_W];
	logic [MANT_W-1:0]     mant_s [0:LOG_FRAC_W-1];

	always_comb begin
		lead = '0;
		for (int i = 0; i < FREQ_W; i++) begin
			if (x[i]) begin
				lead = LOG_INT_W'(i);
			end
		end
		mant0 = MANT_W'(x) << (5'd30 - {1'b0, lead});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x == '0);
			exp_s[0]  <= lead;
			frac_s[0] <= '0;
			mant_s[0] <= mant0;
		end
	end

	for (genvar k = 0; k < LOG_FRAC_W; k++) begin : g_sq
		logic [2*MANT_W-1:0] sq;
		logic [MANT_W:0]     top;
		logic                bit_k;

		assign sq    = mant_s[k] * mant_s[k];
		assign top   = sq[2*MANT_W-1:MANT_W-1];
		assign bit_k = top[MANT_W];

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k+1] <= zero_s[k];
				exp_s[k+1]  <= exp_s[k];
				frac_s[k+1] <= {frac_s[k][LOG_FRAC_W-2:0], bit_k};
			end
		end

		if (k < LOG_FRAC_W - 1) begin : g_mant
			always_ff @(posedge clk) begin
				if (en) begin
					mant_s[k+1] <= bit_k ? top[MANT_W:1] : top[MANT_W-1:0];
				end
			end
		end
	end

	assign log_q16 = zero_s[LOG_FRAC_W] ? '0 : {exp_s[LOG_FRAC_W], frac_s[LOG_FRAC_W]};

endmodule

### design/voice_note_segmenter_core.sv
// ---------------------------------------------------------------------------
// Voice note segmenter - top level
// Splits per-voice tone samples into notes with pitch bands and merges.
// ---------------------------------------------------------------------------
// Usage:
//   tick_ch carries attack polls (kind 0) and voice ticks (kind 1) on a
//   valid/ready handshake. note_ch returns one word per voice tick whose
//   voice number is below NUM_VOICES; polls and out-of-range voices give none.
//   cfg_wr_en/cfg_index/cfg_data write the five settings while the block is
//   empty; an unknown index is ignored.
// Timing:
//   One item per cycle while the output buffer is not full. A word passes the
//   log2 pipeline (one normalize stage, then one mantissa squaring per
//   fraction bit), one pitch stage and one per-voice state update.
// Stall and reset:
//   Results sit in a two-word output buffer. While it is full the whole
//   pipeline holds and tick_ch.ready is low; it never drops a word.
//   Reset clears every voice's state and the buffer and loads the default
//   settings; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "voice_note_segmenter_core_defines.svh"

module voice_note_segmenter_core import vns_pkg::*; #(
	parameter int NUM_VOICES      = 3,
	parameter int PITCH_FRAC_BITS = 8,
	parameter int TICK_BITS       = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	vns_in_if.sink                tick_ch,
	vns_out_if.source             note_ch
);

	localparam int VIDX_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int ATK_N    = (NUM_VOICES < ATTACK_W) ? NUM_VOICES : ATTACK_W;
	localparam int PSUM_W   = 25;
	localparam int PSHIFT   = 16 - PITCH_FRAC_BITS;
	localparam logic [PSUM_W-1:0] PROUND = PSUM_W'(1) << (15 - PITCH_FRAC_BITS);
	localparam int NSUM_W   = PITCH_W + 2;
	localparam logic [NSUM_W-1:0] NROUND = NSUM_W'(1) << PITCH_FRAC_BITS;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef struct packed {
		logic                 prev_gate;
		logic                 prev_attack;
		logic                 retrig;
		logic                 prev_audible;
		logic [PITCH_W-1:0]   last_pitch;
		logic [PITCH_W-1:0]   band_low;
		logic [PITCH_W-1:0]   band_high;
		logic [PITCH_W-1:0]   old_low;
		logic [PITCH_W-1:0]   old_high;
		logic [TICK_BITS-1:0] seg_start;
		logic [TICK_BITS-1:0] old_seg_start;
		dir_t                 last_dir;
		logic                 oscillating;
		logic                 split_was_band;
		logic [TICK_BITS-1:0] note_start;
	} vstate_t;

	// settings
	logic [FREQ_W-1:0]  min_freq_q, max_freq_q;
	logic [PITCH_W-1:0] jump_limit_q, slide_band_q, vibrato_band_q;
	logic [FREQ_W-1:0]  ref_freq;

	// pipeline
	logic                  pipe_en, accept;
	logic [LOG_LAT-1:0]    vld_s;
	in_item_t              item_s [0:LOG_LAT-1];
	logic                  vld_s18;
	in_item_t              item_s18;
	logic [PITCH_W-1:0]    pitch_s18;
	logic [LOG_W-1:0]      log_freq, log_ref;
	logic [LOG_W-1:0]      log_diff;
	logic [PSUM_W-1:0]     psum;
	logic [PSUM_W-1:0]     pshift;
	logic [PITCH_W-1:0]    pitch_calc;

	// voice state
	vstate_t               vs_q [NUM_VOICES];
	vstate_t               cur, nx;
	logic [VIDX_W-1:0]     vidx;
	logic                  voice_ok, fire, push;
	out_res_t              res;

	// output buffer
	out_res_t              buf_q [2];
	logic                  wr_ptr_q, rd_ptr_q;
	logic [1:0]            cnt_q;
	logic                  pop;

	assign ref_freq = (min_freq_q == '0) ? FREQ_W'(1) : min_freq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_freq_q     <= RST_MIN_FREQ;
			max_freq_q     <= RST_MAX_FREQ;
			jump_limit_q   <= RST_JUMP_LIMIT;
			slide_band_q   <= RST_SLIDE_BAND;
			vibrato_band_q <= RST_VIBRATO_BAND;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MIN_FREQ:     min_freq_q     <= cfg_data;
				REG_MAX_FREQ:     max_freq_q     <= cfg_data;
				REG_JUMP_LIMIT:   jump_limit_q   <= cfg_data[PITCH_W-1:0];
				REG_SLIDE_BAND:   slide_band_q   <= cfg_data[PITCH_W-1:0];
				REG_VIBRATO_BAND: vibrato_band_q <= cfg_data[PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline holds only when both buffer slots are taken
	assign pipe_en       = (cnt_q != 2'd2);
	assign tick_ch.ready = pipe_en;
	assign accept        = tick_ch.valid && pipe_en;

	vns_log2 u_log_freq (
		.clk     (clk),
		.en      (pipe_en),
		.x       (tick_ch.payload.freq_word),
		.log_q16 (log_freq)
	);

	vns_log2 u_log_ref (
		.clk     (clk),
		.en      (pipe_en),
		.x       (ref_freq),
		.log_q16 (log_ref)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s   <= '0;
			vld_s18 <= 1'b0;
		end else if (pipe_en) begin
			vld_s   <= {vld_s[LOG_LAT-2:0], accept};
			vld_s18 <= vld_s[LOG_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			item_s[0] <= tick_ch.payload;
			for (int k = 1; k < LOG_LAT; k++) begin
				item_s[k] <= item_s[k-1];
			end
			item_s18  <= item_s[LOG_LAT-1];
			pitch_s18 <= pitch_calc;
		end
	end

	// pitch = 12 * (log f - log ref), rounded to the pitch fraction, saturated
	always_comb begin
		log_diff   = (log_freq > log_ref) ? (log_freq - log_ref) : '0;
		psum       = (PSUM_W'(log_diff) << 3) + (PSUM_W'(log_diff) << 2) + PROUND;
		pshift     = psum >> PSHIFT;
		pitch_calc = (pshift > PSUM_W'(PITCH_MAX)) ? PITCH_MAX : pshift[PITCH_W-1:0];
	end

	assign vidx     = VIDX_W'(item_s18.voice);
	assign voice_ok = (32'(item_s18.voice) < NUM_VOICES);
	assign fire     = vld_s18 && pipe_en;

	always_comb begin
		logic                 gate, gate_rise, retrig, audible, new_note;
		logic                 band_split, up, down;
		logic [LEVEL_W-1:0]   vol;
		logic [INST_W-1:0]    wave;
		logic [PITCH_W-1:0]   p, mag, ulo, uhi, lim;
		logic [TICK_BITS-1:0] tick_w;
		logic [NSUM_W-1:0]    nsum;
		logic [NSUM_W-1:0]    nval;
		dir_t                 dir;

		cur  = vs_q[vidx];
		nx   = cur;
		push = 1'b0;
		res  = '0;
		res.out_voice = item_s18.voice;

		gate      = item_s18.control[0];
		gate_rise = gate && !cur.prev_gate;
		retrig    = cur.retrig;
		vol       = item_s18.env_valid ? item_s18.envelope : (gate ? LEVEL_FULL : '0);
		wave      = item_s18.control[CTRL_W-1:CTRL_W-INST_W];
		audible   = (wave != '0) && (item_s18.freq_word >= ref_freq)
			&& (item_s18.freq_word <= max_freq_q) && (vol != '0);
		p         = pitch_s18;
		tick_w    = TICK_BITS'(item_s18.tick);
		up        = p > cur.last_pitch;
		down      = p < cur.last_pitch;
		mag       = up ? (p - cur.last_pitch) : (cur.last_pitch - p);
		dir       = up ? DIR_UP : DIR_DOWN;
		ulo       = (cur.band_low < cur.old_low) ? cur.band_low : cur.old_low;
		uhi       = (cur.band_high > cur.old_high) ? cur.band_high : cur.old_high;
		band_split = 1'b0;
		new_note   = 1'b0;
		lim        = '0;
		nsum       = '0;
		nval       = '0;

		if (fire && item_s18.kind == KIND_VOICE && voice_ok) begin
			push = 1'b1;
			res.note_start_tick = IO_TICK_W'(cur.note_start);
			if (!item_s18.regs_valid) begin
				nx.prev_audible = 1'b0;
			end else begin
				nx.prev_gate = gate;
				nx.retrig    = 1'b0;
				if (!audible) begin
					nx.prev_audible = 1'b0;
				end else begin
					new_note = !cur.prev_audible || gate_rise || retrig;
					if (!new_note) begin
						if (mag > jump_limit_q) begin
							new_note = 1'b1;
						end else begin
							if (up || down) begin
								// reversal: the earlier band split may have been vibrato
								if (cur.last_dir != DIR_NONE && dir != cur.last_dir) begin
									nx.oscillating = 1'b1;
									if (cur.split_was_band && uhi >= ulo
										&& (uhi - ulo) <= vibrato_band_q) begin
										res.merge_back        = 1'b1;
										res.merge_first_tick  = IO_TICK_W'(cur.seg_start);
										res.merge_target_tick = IO_TICK_W'(cur.old_seg_start);
										nx.band_low       = ulo;
										nx.band_high      = uhi;
										nx.seg_start      = cur.old_seg_start;
										nx.note_start     = cur.old_seg_start;
										nx.split_was_band = 1'b0;
									end
								end
								nx.last_dir = dir;
							end
							if (p < nx.band_low) begin
								nx.band_low = p;
							end
							if (p > nx.band_high) begin
								nx.band_high = p;
							end
							lim = nx.oscillating ? vibrato_band_q : slide_band_q;
							if (nx.band_high >= nx.band_low
								&& (nx.band_high - nx.band_low) > lim) begin
								new_note   = 1'b1;
								band_split = 1'b1;
							end
						end
					end
					if (new_note) begin
						nx.old_low        = nx.band_low;
						nx.old_high       = nx.band_high;
						nx.old_seg_start  = nx.seg_start;
						nx.band_low       = p;
						nx.band_high      = p;
						nx.seg_start      = tick_w;
						nx.last_dir       = DIR_NONE;
						nx.oscillating    = 1'b0;
						nx.split_was_band = band_split;
						nx.note_start     = tick_w;
					end
					nx.last_pitch   = p;
					nx.prev_audible = 1'b1;

					nsum = NSUM_W'(nx.band_low) + NSUM_W'(nx.band_high) + NROUND;
					nval = (nsum >> (PITCH_FRAC_BITS + 1)) + NSUM_W'(1);
					res.volume          = vol;
					res.instrument      = wave;
					res.note_pitch      = (nval > NSUM_W'(NOTE_MAX)) ? NOTE_MAX
						: nval[NOTE_W-1:0];
					res.note_start_tick = IO_TICK_W'(nx.note_start);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vs_q <= '{default: '0};
		end else if (fire) begin
			if (item_s18.kind == KIND_ATTACK) begin
				// latch attack rising edges as pending retriggers
				for (int c = 0; c < ATK_N; c++) begin
					if (item_s18.attack_bits[c] && !vs_q[c].prev_attack) begin
						vs_q[c].retrig <= 1'b1;
					end
					vs_q[c].prev_attack <= item_s18.attack_bits[c];
				end
			end else if (voice_ok) begin
				vs_q[vidx] <= nx;
			end
		end
	end

	// two-word output buffer
	assign pop             = note_ch.valid && note_ch.ready;
	assign note_ch.valid   = (cnt_q != 2'd0);
	assign note_ch.payload = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= res;
		end
	end

	`VNS_ASSERT_NEXT(a_stall_holds_pipe, !pipe_en, $stable(vld_s) && $stable(vld_s18),
		"pipeline moved while output buffer was full")
	`VNS_ASSERT_NOW(a_poll_no_word, vld_s18 && item_s18.kind == KIND_ATTACK, !push,
		"attack poll produced a result word")
	`VNS_ASSERT_NOW(a_silent_no_note, push,
		(res.volume == '0) == (res.note_pitch == '0),
		"volume and note pitch disagree on audibility")

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Voice note segmenter - testbench
// Drives attack polls and voice ticks through the tick channel, predicts each
// note word from a per-voice model of the segmenter kept here, and compares
// every word taken from the note channel field by field. Runs directed rows,
// then random phases under several register settings, with random gaps and
// stalls on both channels and one long hold on the result side.
// ---------------------------------------------------------------------------
module tb;
	import vns_pkg::*;

	localparam int VOICES      = 3;
	localparam int FRAC        = 8;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 70;
	localparam int SETTLE      = 30;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT       = 400000;

	typedef enum logic [1:0] {DIR_NONE = 2'd0, DIR_UP = 2'd1, DIR_DOWN = 2'd2} slope_e;

	typedef struct {
		bit        prev_gate, prev_attack, retrig_pend, prev_audible;
		bit [14:0] last_pitch, band_lo, band_hi, old_lo, old_hi;
		bit [19:0] seg_start, old_seg_start;
		slope_e    last_dir;
		bit        oscillating, split_was_band;
		bit [19:0] note_start;
	} voice_track_t;

	typedef struct {
		in_item_t item;
		bit       typed;
		out_res_t want;
	} row_t;

	typedef struct {
		bit [15:0] min_f, max_f;
		bit [14:0] jump, slide, vib;
	} setting_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	vns_in_if tick_ch ();
	vns_out_if note_ch ();

	voice_note_segmenter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick_ch   (tick_ch),
		.note_ch   (note_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// model of the block
	voice_track_t vt [VOICES];
	bit [15:0] set_min = RST_MIN_FREQ;
	bit [15:0] set_max = RST_MAX_FREQ;
	bit [14:0] set_jump = RST_JUMP_LIMIT;
	bit [14:0] set_slide = RST_SLIDE_BAND;
	bit [14:0] set_vib = RST_VIBRATO_BAND;

	out_res_t note_want_q [$];
	out_res_t popped_word, predicted_word;
	int mismatch_cnt = 0;
	int cycles = 0;

	// driver shared state
	bit       row_typed = 1'b0;
	out_res_t row_want = '0;
	bit       hold_req = 1'b0;
	bit       hold_active = 1'b0;
	int       burst_left = 0;

	// random walk per voice
	int        walk_freq [VOICES];
	bit        walk_up [VOICES];
	bit [3:0]  walk_wave [VOICES];
	bit [19:0] walk_tick [VOICES];
	int        walk_lo, walk_hi;

	function automatic bit [19:0] log2_fixed(input bit [15:0] x);
		int        e;
		bit [15:0] frac;
		bit [63:0] m;
		if (x == 0)
			return '0;
		e = 15;
		while (x[e] == 1'b0)
			e--;
		m = 64'(x) << (30 - e);
		frac = '0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'h8000_0000) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return {4'(e), frac};
	endfunction

	function automatic bit [14:0] pitch_q8(input bit [15:0] f, input bit [15:0] refq);
		bit [19:0] lf, lr;
		bit [63:0] d, p;
		lf = log2_fixed(f);
		lr = log2_fixed(refq);
		d = (lf > lr) ? 64'(lf - lr) : 64'd0;
		p = (d * 12 + (64'd1 << (15 - FRAC))) >> (16 - FRAC);
		return (p > 64'(PITCH_MAX)) ? PITCH_MAX : p[14:0];
	endfunction

	// updates the voice state for one item; returns 1 when a word is due
	function automatic bit predict_note(input in_item_t it, output out_res_t r);
		int unsigned c;
		bit        gate, rise, retrig, ok, fresh, split, merged;
		bit [7:0]  vol;
		bit [3:0]  wave;
		bit [15:0] refq;
		bit [14:0] p, ulo, uhi, lim;
		bit [19:0] m_first, m_target;
		int        step, mag, note;
		slope_e    dir;
		r = '0;
		split = 1'b0;
		merged = 1'b0;
		m_first = '0;
		m_target = '0;
		if (it.kind == KIND_ATTACK) begin
			for (int i = 0; i < VOICES; i++) begin
				if (it.attack_bits[i] && !vt[i].prev_attack)
					vt[i].retrig_pend = 1'b1;
				vt[i].prev_attack = it.attack_bits[i];
			end
			return 1'b0;
		end
		c = it.voice;
		if (c >= VOICES)
			return 1'b0;
		r.out_voice = it.voice;
		if (!it.regs_valid) begin
			vt[c].prev_audible = 1'b0;
			r.note_start_tick = vt[c].note_start;
			return 1'b1;
		end
		gate = it.control[0];
		rise = gate && !vt[c].prev_gate;
		vt[c].prev_gate = gate;
		retrig = vt[c].retrig_pend;
		vt[c].retrig_pend = 1'b0;
		vol = it.env_valid ? it.envelope : (gate ? LEVEL_FULL : 8'd0);
		wave = it.control[7:4];
		refq = (set_min == 0) ? 16'd1 : set_min;
		ok = (wave != 0) && (it.freq_word >= refq) && (it.freq_word <= set_max);
		if (!ok || vol == 0) begin
			vt[c].prev_audible = 1'b0;
			r.note_start_tick = vt[c].note_start;
			return 1'b1;
		end
		p = pitch_q8(it.freq_word, refq);
		fresh = !vt[c].prev_audible || rise || retrig;
		if (!fresh) begin
			step = int'(p) - int'(vt[c].last_pitch);
			mag = (step < 0) ? -step : step;
			if (mag > int'(set_jump)) begin
				fresh = 1'b1;
			end else begin
				if (step != 0) begin
					dir = (step > 0) ? DIR_UP : DIR_DOWN;
					if (vt[c].last_dir != DIR_NONE && dir != vt[c].last_dir) begin
						// reversal: vibrato, and maybe undo the last band split
						ulo = (vt[c].band_lo < vt[c].old_lo) ? vt[c].band_lo : vt[c].old_lo;
						uhi = (vt[c].band_hi > vt[c].old_hi) ? vt[c].band_hi : vt[c].old_hi;
						vt[c].oscillating = 1'b1;
						if (vt[c].split_was_band && uhi >= ulo && uhi - ulo <= set_vib) begin
							merged = 1'b1;
							m_first = vt[c].seg_start;
							m_target = vt[c].old_seg_start;
							vt[c].band_lo = ulo;
							vt[c].band_hi = uhi;
							vt[c].seg_start = vt[c].old_seg_start;
							vt[c].note_start = vt[c].old_seg_start;
							vt[c].split_was_band = 1'b0;
						end
					end
					vt[c].last_dir = dir;
				end
				if (p < vt[c].band_lo)
					vt[c].band_lo = p;
				if (p > vt[c].band_hi)
					vt[c].band_hi = p;
				lim = vt[c].oscillating ? set_vib : set_slide;
				if (vt[c].band_hi >= vt[c].band_lo && vt[c].band_hi - vt[c].band_lo > lim) begin
					fresh = 1'b1;
					split = 1'b1;
				end
			end
		end
		if (fresh) begin
			vt[c].old_lo = vt[c].band_lo;
			vt[c].old_hi = vt[c].band_hi;
			vt[c].old_seg_start = vt[c].seg_start;
			vt[c].band_lo = p;
			vt[c].band_hi = p;
			vt[c].seg_start = it.tick;
			vt[c].last_dir = DIR_NONE;
			vt[c].oscillating = 1'b0;
			vt[c].split_was_band = split;
			vt[c].note_start = it.tick;
		end
		note = ((int'(vt[c].band_lo) + int'(vt[c].band_hi) + (1 << FRAC)) >> (FRAC + 1)) + 1;
		vt[c].last_pitch = p;
		vt[c].prev_audible = 1'b1;
		r.volume = vol;
		r.instrument = wave;
		r.note_pitch = (note > int'(NOTE_MAX)) ? NOTE_MAX : 7'(note);
		r.note_start_tick = vt[c].note_start;
		r.merge_back = merged;
		r.merge_first_tick = m_first;
		r.merge_target_tick = m_target;
		return 1'b1;
	endfunction

	task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_MIN_FREQ:     set_min = d;
			REG_MAX_FREQ:     set_max = d;
			REG_JUMP_LIMIT:   set_jump = d[14:0];
			REG_SLIDE_BAND:   set_slide = d[14:0];
			REG_VIBRATO_BAND: set_vib = d[14:0];
			default: ;
		endcase
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
		mismatch_cnt++;
		if (mismatch_cnt <= 50)
			$display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
	endtask

	task automatic check_note(input out_res_t got, input out_res_t want);
		if (got.out_voice !== want.out_voice)
			flag_mismatch("out_voice", got.out_voice, want.out_voice);
		if (got.volume !== want.volume)
			flag_mismatch("volume", got.volume, want.volume);
		if (got.instrument !== want.instrument)
			flag_mismatch("instrument", got.instrument, want.instrument);
		if (got.note_pitch !== want.note_pitch)
			flag_mismatch("note_pitch", got.note_pitch, want.note_pitch);
		if (got.note_start_tick !== want.note_start_tick)
			flag_mismatch("note_start_tick", got.note_start_tick, want.note_start_tick);
		if (got.merge_back !== want.merge_back)
			flag_mismatch("merge_back", got.merge_back, want.merge_back);
		if (got.merge_first_tick !== want.merge_first_tick)
			flag_mismatch("merge_first_tick", got.merge_first_tick, want.merge_first_tick);
		if (got.merge_target_tick !== want.merge_target_tick)
			flag_mismatch("merge_target_tick", got.merge_target_tick, want.merge_target_tick);
	endtask

	// both channels and the register port are sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (note_ch.valid && note_ch.ready) begin
				if (note_want_q.size() == 0) begin
					flag_mismatch("word with nothing pending", note_ch.payload.note_start_tick, '0);
				end else begin
					popped_word = note_want_q.pop_front();
					check_note(note_ch.payload, popped_word);
				end
			end
			if (tick_ch.valid && tick_ch.ready) begin
				if (predict_note(tick_ch.payload, predicted_word))
					note_want_q.push_back(row_typed ? row_want : predicted_word);
			end
			if (cfg_wr_en)
				apply_setting(cfg_index, cfg_data);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic in_item_t mk_tick(input int v, input bit [19:0] t, input bit regs,
			input bit envv, input bit [15:0] f, input bit [7:0] ctrl, input bit [7:0] env);
		in_item_t it;
		it = '0;
		it.kind = KIND_VOICE;
		it.voice = 2'(v);
		it.tick = t;
		it.regs_valid = regs;
		it.env_valid = envv;
		it.freq_word = f;
		it.control = ctrl;
		it.envelope = env;
		return it;
	endfunction

	function automatic in_item_t mk_poll(input bit [2:0] bits);
		in_item_t it;
		it = '0;
		it.kind = KIND_ATTACK;
		it.attack_bits = bits;
		return it;
	endfunction

	function automatic out_res_t mk_res(input int v, input bit [7:0] vol, input bit [3:0] inst,
			input bit [6:0] note, input bit [19:0] start);
		out_res_t r;
		r = '0;
		r.out_voice = 2'(v);
		r.volume = vol;
		r.instrument = inst;
		r.note_pitch = note;
		r.note_start_tick = start;
		return r;
	endfunction

	function automatic int sender_gap();
		int unsigned r;
		if (hold_active)
			return 0;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			burst_left = $urandom_range(20, 60);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_item(input in_item_t it, input bit typed, input out_res_t want);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			@(negedge clk);
			tick_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		tick_ch.valid <= 1'b1;
		tick_ch.payload <= it;
		row_typed <= typed;
		row_want <= want;
		do
			@(posedge clk);
		while (!tick_ch.ready);
	endtask

	task automatic wait_drained(input int settle);
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		while (note_want_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
	endtask

	task automatic make_random_item(output in_item_t it, output bit counted);
		int unsigned r, c;
		int          f, d;
		bit [63:0]   raw;
		counted = 1'b1;
		r = $urandom_range(0, 99);
		raw = {$urandom, $urandom};
		c = $urandom_range(0, VOICES - 1);
		if (r < 6) begin
			it = mk_poll(3'($urandom_range(0, 7)));
		end else if (r < 8) begin
			// out-of-range voice, dropped by the block
			it = raw[$bits(in_item_t)-1:0];
			it.kind = KIND_VOICE;
			it.voice = 2'd3;
			counted = 1'b0;
		end else if (r < 18) begin
			it = raw[$bits(in_item_t)-1:0];
			it.kind = KIND_VOICE;
			if (it.voice == 2'd3)
				it.voice = 2'(c);
		end else if (r < 23) begin
			// silent tick: gate off without envelope, or no register snapshot
			walk_tick[c]++;
			it = mk_tick(c, walk_tick[c], $urandom_range(0, 1), 1'b0, 16'(walk_freq[c]),
				{walk_wave[c], 3'($urandom_range(0, 7)), 1'b0}, 8'($urandom));
		end else begin
			f = walk_freq[c];
			if ($urandom_range(0, 9) == 0) begin
				f = $urandom_range(walk_lo, walk_hi);
			end else begin
				if ($urandom_range(0, 3) == 0)
					walk_up[c] = !walk_up[c];
				d = $urandom_range(0, (f >> 6) + 2);
				f = walk_up[c] ? f + d : f - d;
				if (f < walk_lo)
					f = walk_lo;
				if (f > walk_hi)
					f = walk_hi;
			end
			walk_freq[c] = f;
			if ($urandom_range(0, 19) == 0)
				walk_wave[c] = 4'($urandom_range(1, 15));
			walk_tick[c]++;
			it = mk_tick(c, walk_tick[c], 1'b1, $urandom_range(0, 99) < 85, 16'(f),
				{walk_wave[c], 3'($urandom_range(0, 7)), 1'($urandom_range(0, 19) != 0)},
				8'($urandom_range(1, 255)));
		end
	endtask

	// result side: random stalls, ready stretches, and one long hold on request
	initial begin : note_sink
		int stall_left, run_left, held;
		int unsigned r;
		stall_left = 0;
		run_left = 0;
		note_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				note_ch.ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
				hold_active = 1'b0;
			end else if (stall_left > 0) begin
				note_ch.ready <= 1'b0;
				stall_left--;
			end else if (run_left > 0) begin
				note_ch.ready <= 1'b1;
				run_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5)
					run_left = $urandom_range(30, 80);
				if (r < 70) begin
					note_ch.ready <= 1'b1;
				end else begin
					note_ch.ready <= 1'b0;
					stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
				end
			end
		end
	end

	initial begin : stimulus
		row_t     rows [$];
		setting_t phase_cfg [PHASES];
		setting_t cfg;
		in_item_t it;
		bit       counted, hold_done;
		int       n;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tick_ch.valid = 1'b0;
		tick_ch.payload = '0;
		hold_done = 1'b0;

		// defaults, extremes, then a mix; min above max leaves every tick invalid
		phase_cfg[0] = '{RST_MIN_FREQ, RST_MAX_FREQ, RST_JUMP_LIMIT, RST_SLIDE_BAND,
			RST_VIBRATO_BAND};
		phase_cfg[1] = '{16'd0, 16'd65535, 15'd0, 15'd0, 15'd0};
		phase_cfg[2] = '{16'd1, 16'd65535, 15'd32767, 15'd32767, 15'd32767};
		phase_cfg[3] = '{16'd65535, 16'd65535, 15'd179, 15'd307, 15'd640};
		phase_cfg[4] = '{16'd279, 16'd65535, 15'd179, 15'd307, 15'd640};
		phase_cfg[5] = '{16'd5000, 16'd1000, 15'd100, 15'd200, 15'd500};
		phase_cfg[6] = '{16'd100, 16'd40000, 15'd100, 15'd200, 15'd500};

		// directed rows under the reset settings
		rows.push_back('{mk_tick(0, 5, 0, 0, 0, 8'h00, 0), 1'b1, mk_res(0, 0, 0, 0, 0)});
		rows.push_back('{mk_poll(3'b111), 1'b0, '0});
		rows.push_back('{mk_tick(0, 10, 1, 1, 279, 8'h11, 200), 1'b1,
			mk_res(0, 200, 1, 1, 10)});
		rows.push_back('{mk_tick(0, 11, 1, 0, 279, 8'h11, 0), 1'b1, mk_res(0, 255, 1, 1, 10)});
		rows.push_back('{mk_tick(0, 12, 1, 0, 279, 8'h10, 0), 1'b1, mk_res(0, 0, 0, 0, 10)});
		rows.push_back('{mk_tick(0, 13, 1, 1, 278, 8'h11, 100), 1'b1, mk_res(0, 0, 0, 0, 10)});
		rows.push_back('{mk_tick(0, 14, 1, 1, 279, 8'h01, 100), 1'b1, mk_res(0, 0, 0, 0, 10)});
		rows.push_back('{mk_tick(1, 20, 1, 1, 65535, 8'hF1, 255), 1'b0, '0});
		rows.push_back('{mk_tick(2, 30, 1, 1, 0, 8'hF1, 255), 1'b1, mk_res(2, 0, 0, 0, 0)});
		rows.push_back('{mk_tick(3, 40, 1, 1, 1000, 8'h21, 128), 1'b0, '0});
		// upward slide past the slide band, then a reversal that merges back
		rows.push_back('{mk_tick(2, 31, 1, 1, 1000, 8'h21, 128), 1'b0, '0});
		rows.push_back('{mk_tick(2, 32, 1, 1, 1020, 8'h21, 128), 1'b0, '0});
		rows.push_back('{mk_tick(2, 33, 1, 1, 1040, 8'h21, 128), 1'b0, '0});
		rows.push_back('{mk_tick(2, 34, 1, 1, 1061, 8'h21, 128), 1'b0, '0});
		rows.push_back('{mk_tick(2, 35, 1, 1, 1082, 8'h21, 128), 1'b0, '0});
		rows.push_back('{mk_tick(2, 36, 1, 1, 1103, 8'h21, 128), 1'b0, '0});
		rows.push_back('{mk_tick(2, 37, 1, 1, 1082, 8'h21, 128), 1'b0, '0});
		// gate off with envelope still up, then gate rise
		rows.push_back('{mk_tick(2, 38, 1, 1, 1082, 8'h20, 50), 1'b0, '0});
		rows.push_back('{mk_tick(2, 39, 1, 1, 1082, 8'h21, 50), 1'b0, '0});
		// attack edge on voice 2 only, then retrigger
		rows.push_back('{mk_poll(3'b000), 1'b0, '0});
		rows.push_back('{mk_poll(3'b100), 1'b0, '0});
		rows.push_back('{mk_tick(2, 40, 1, 1, 1082, 8'h21, 90), 1'b0, '0});
		rows.push_back('{mk_tick(2, 41, 1, 1, 2000, 8'h21, 90), 1'b0, '0});
		rows.push_back('{mk_tick(1, 20'hFFFFF, 1, 0, 65535, 8'hF1, 0), 1'b0, '0});
		rows.push_back('{mk_tick(0, 15, 1, 1, 65535, 8'hFE, 255), 1'b0, '0});

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			send_item(rows[i].item, rows[i].typed, rows[i].want);
		wait_drained(SETTLE);

		for (int ph = 0; ph < PHASES; ph++) begin
			cfg = phase_cfg[ph];
			if (ph == 4) begin
				cfg.min_f = $urandom_range(1, 2000);
				cfg.max_f = $urandom_range(cfg.min_f, 65535);
				cfg.jump = $urandom_range(0, 1000);
				cfg.slide = $urandom_range(0, 1000);
				cfg.vib = $urandom_range(0, 1000);
			end
			cfg_write(REG_MIN_FREQ, cfg.min_f);
			cfg_write(REG_MAX_FREQ, cfg.max_f);
			cfg_write(REG_JUMP_LIMIT, 16'(cfg.jump));
			cfg_write(REG_SLIDE_BAND, 16'(cfg.slide));
			cfg_write(REG_VIBRATO_BAND, 16'(cfg.vib));
			@(negedge clk);
			cfg_wr_en <= 1'b0;

			walk_lo = (cfg.min_f == 0) ? 1 : cfg.min_f;
			walk_hi = (cfg.max_f < walk_lo) ? walk_lo : cfg.max_f;
			for (int c = 0; c < VOICES; c++) begin
				walk_freq[c] = $urandom_range(walk_lo, walk_hi);
				walk_up[c] = $urandom_range(0, 1);
				walk_wave[c] = 4'($urandom_range(1, 15));
				walk_tick[c] = 20'($urandom);
			end

			n = 0;
			while (n < PHASE_ITEMS) begin
				if (ph == 2 && n == 20 && !hold_done) begin
					// note side stops while ticks keep coming, so the pipeline backs up
					hold_done = 1'b1;
					hold_active = 1'b1;
					hold_req = 1'b1;
				end
				if (ph == 4 && n == 35)
					wait_drained(0);
				make_random_item(it, counted);
				send_item(it, 1'b0, '0);
				if (counted)
					n++;
			end
			wait_drained(SETTLE);
		end

		if (mismatch_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### voice_note_segmenter_core.f
+incdir+design
design/vns_pkg.sv
design/vns_in_if.sv
design/vns_out_if.sv
design/vns_log2.sv
design/voice_note_segmenter_core.sv
test/tb.sv
